// ----- rtl/core/blm_pkg.sv -----
// shared constants, widths and helpers for the loudness meter
package blm_pkg;

  localparam int unsigned BLOCKS_AVERAGED_DEF  = 10;
  localparam int unsigned MAX_BLOCK_LENGTH_DEF = 4096;

  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned BLEN_W      = 13;
  localparam int unsigned LOUD_W      = 15;
  localparam int unsigned LEVEL_W     = 3;
  localparam int unsigned VALID_W     = 7;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned DIV_DW      = 8;

  localparam int unsigned FRAC_W = 16;
  localparam int unsigned MANT_W = 31;

  localparam logic [BLEN_W-1:0] BLEN_RESET = 13'd400;

  localparam logic signed [LOUD_W-1:0] SILENCE_CB = -15'sd7000;
  localparam logic signed [LOUD_W-1:0] CB_MIN     = -15'sd16384;
  localparam logic signed [LOUD_W-1:0] CB_MAX     = 15'sd16383;

  // 100 * log10(2) in 1e-3 units
  localparam logic signed [15:0] LOG_K = 16'sd30103;
  // dB offset in 1e-4 dB units plus the half for rounding, applied after the q16 shift
  localparam int DB_OFS_CB = -1019099;

  // floor division by 100 as a reciprocal multiply on a biased, non-negative numerator
  localparam int CB_SCALE      = 100;
  localparam int CB_BIAS_Q     = 16384;
  localparam int DB_OFS_BIASED = DB_OFS_CB + CB_SCALE * CB_BIAS_Q;
  localparam int unsigned RCP_MW   = 22;
  localparam int unsigned RCP_CW   = 23;
  localparam int unsigned CB_SHIFT = 29;
  // ceil(2^29 / 100), exact for numerators below 2^22
  localparam logic [RCP_CW-1:0] CB_RECIP = 23'd5368710;

  localparam logic signed [LOUD_W-1:0] LVL_T0 = -15'sd6000;
  localparam logic signed [LOUD_W-1:0] LVL_T1 = -15'sd5000;
  localparam logic signed [LOUD_W-1:0] LVL_T2 = -15'sd4000;
  localparam logic signed [LOUD_W-1:0] LVL_T3 = -15'sd3000;
  localparam logic signed [LOUD_W-1:0] LVL_T4 = -15'sd2000;
  localparam logic signed [LOUD_W-1:0] LVL_T5 = -15'sd1000;

  function automatic logic [LEVEL_W-1:0] level_code(input logic signed [LOUD_W-1:0] cb);
    logic [LEVEL_W-1:0] lv;
    if (cb < LVL_T0) lv = 3'd0;
    else if (cb < LVL_T1) lv = 3'd1;
    else if (cb < LVL_T2) lv = 3'd2;
    else if (cb < LVL_T3) lv = 3'd3;
    else if (cb < LVL_T4) lv = 3'd4;
    else if (cb < LVL_T5) lv = 3'd5;
    else lv = 3'd6;
    return lv;
  endfunction

endpackage

// ----- rtl/core/block_loudness_meter.sv -----
// loudness meter top level: sample path, block sequencer, value ring and output word
// Usage:
//   s_axis carries one signed 16-bit pcm sample per word; zero samples are
//   dropped. a kept sample goes through difference, square and accumulate
//   steps and tready is low meanwhile.
//   cfg_valid_i/cfg_data_i write block_length (kept samples per block); write
//   it only while the block is idle.
//   the last sample of a block then goes through two passes of the shared
//   log2 unit (a leading-one shift search, then repeated squaring), a
//   multiply and a reciprocal divide by 100 with saturation.
//   when the ring of BLOCKS_AVERAGED block values wraps, the ring is walked
//   entry by entry and its non-silent values averaged with a serial division;
//   one word then goes to m_axis: loudness in 0.01 dB, level code and valid count.
//   the result sits in an output register; a stalled receiver holds it and
//   the block keeps taking samples, waiting only if the next result is ready
//   before the previous one is taken.
//   reset clears the sum, count and ring position and sets block_length to
//   400; ring entries are all written before they are read.
module block_loudness_meter import blm_pkg::*; #(
  parameter int unsigned BLOCKS_AVERAGED  = BLOCKS_AVERAGED_DEF,
  parameter int unsigned MAX_BLOCK_LENGTH = MAX_BLOCK_LENGTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [SAMPLE_W-1:0]    s_axis_tdata,   // [15:0] sample
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [14:0] loudness_cb, [17:15] level,
                                                 // [24:18] valid_blocks, rest zero
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [BLEN_W-1:0]      cfg_data_i
);

  localparam int unsigned CW   = $clog2(MAX_BLOCK_LENGTH + 1);
  localparam int unsigned CMPW = (CW > BLEN_W) ? CW : BLEN_W;
  localparam int unsigned SUMW = 32 + $clog2(MAX_BLOCK_LENGTH);
  localparam int unsigned PW   = $clog2(SUMW);
  localparam int unsigned LW   = PW + FRAC_W;
  localparam int unsigned XW   = LW + 1 + 15 + 2;
  localparam int unsigned ZW   = XW - 16;
  localparam int unsigned RW   = (BLOCKS_AVERAGED > 1) ? $clog2(BLOCKS_AVERAGED) : 1;
  localparam int unsigned AW   = LOUD_W + RW + 1;
  localparam int unsigned RPW  = RCP_MW + RCP_CW;
  localparam int unsigned RQ_W = RPW - CB_SHIFT;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_ACC, S_LOGS, S_LOGN, S_MULX, S_OFS, S_RCP, S_SAT,
    S_WR, S_RD, S_ACCV, S_DIVA, S_WAITA, S_EMIT
  } state_e;

  state_e                     st_q;
  logic [BLEN_W-1:0]          blen_q;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic signed [SAMPLE_W:0]   d_q;
  logic [31:0]                sq_q;
  logic [SUMW-1:0]            sum_q;
  logic [CW-1:0]              cnt_q;
  logic [RW-1:0]              pos_q;
  logic [RW-1:0]              rd_idx_q;
  logic [LW-1:0]              lsum_q;
  logic signed [LW:0]         diff_q;
  logic signed [XW-1:0]       x_q;
  logic [RCP_MW-1:0]          ofs_q;
  logic [RQ_W-1:0]            rq_q;
  logic signed [LOUD_W-1:0]   cb_q;
  logic signed [AW-1:0]       acc_q;
  logic [VALID_W-1:0]         vcnt_q;
  logic signed [LOUD_W-1:0]   avg_q;
  logic                       log_start_q;
  logic [SUMW-1:0]            log_val_q;
  logic                       div_start_q;
  logic signed [ZW-1:0]       div_num_q;
  logic [DIV_DW-1:0]          div_den_q;

  logic                       out_valid_q;
  logic signed [LOUD_W-1:0]   out_cb_q;
  logic [LEVEL_W-1:0]         out_lvl_q;
  logic [VALID_W-1:0]         out_vb_q;

  logic [LOUD_W-1:0]          mem [BLOCKS_AVERAGED];
  logic signed [LOUD_W-1:0]   rdata_q;

  logic                       log_done;
  logic [LW-1:0]              log_res;
  logic                       div_done;
  logic signed [ZW-1:0]       div_quot;

  logic signed [SAMPLE_W-1:0] smp;
  logic signed [2*SAMPLE_W+1:0] sqw;
  logic [SUMW-1:0]            sum_nx;
  logic [CW-1:0]              cnt_nx;
  logic [CMPW-1:0]            blen_x;
  logic [CW-1:0]              len_eff;
  logic [RPW-1:0]             rcp_prod;
  logic signed [RQ_W:0]       cb_raw;
  logic                       s_acc;
  logic                       emit_go;

  assign smp    = $signed(s_axis_tdata);
  assign sqw    = (2*SAMPLE_W+2)'(d_q) * (2*SAMPLE_W+2)'(d_q);
  assign sum_nx = sum_q + SUMW'(sq_q);
  assign cnt_nx = cnt_q + 1'b1;
  assign blen_x = CMPW'(blen_q);
  // biased numerator times the reciprocal of 100
  assign rcp_prod = RPW'(ofs_q) * RPW'(CB_RECIP);
  assign cb_raw   = $signed({1'b0, rq_q}) - $signed((RQ_W+1)'(CB_BIAS_Q));

  always_comb begin
    if (blen_x == '0) len_eff = CW'(1);
    else if (blen_x > CMPW'(MAX_BLOCK_LENGTH)) len_eff = CW'(MAX_BLOCK_LENGTH);
    else len_eff = CW'(blen_x);
  end

  assign s_axis_tready = (st_q == S_IDLE);
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign emit_go       = (st_q == S_EMIT) && (!out_valid_q || m_axis_tready);
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blen_q <= BLEN_RESET;
    end else if (cfg_valid_i) begin
      blen_q <= cfg_data_i;
    end
  end

  blm_log2 #(.VW(SUMW)) u_log2 (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start_q),
    .value_i  (log_val_q),
    .done_o   (log_done),
    .result_o (log_res)
  );

  blm_div #(.NW(ZW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start_q),
    .num_i   (div_num_q),
    .den_i   (div_den_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // block value ring
  always_ff @(posedge clk_i) begin
    if (st_q == S_WR) mem[pos_q] <= cb_q;
    if (st_q == S_RD) rdata_q <= $signed(mem[rd_idx_q]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      prev_q      <= '0;
      d_q         <= '0;
      sq_q        <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      pos_q       <= '0;
      rd_idx_q    <= '0;
      lsum_q      <= '0;
      diff_q      <= '0;
      x_q         <= '0;
      ofs_q       <= '0;
      rq_q        <= '0;
      cb_q        <= '0;
      acc_q       <= '0;
      vcnt_q      <= '0;
      avg_q       <= '0;
      log_start_q <= 1'b0;
      log_val_q   <= '0;
      div_start_q <= 1'b0;
      div_num_q   <= '0;
      div_den_q   <= '0;
      out_valid_q <= 1'b0;
      out_cb_q    <= '0;
      out_lvl_q   <= '0;
      out_vb_q    <= '0;
    end else begin
      log_start_q <= ((st_q == S_ACC) && (cnt_nx >= len_eff) && (sum_nx != '0)) ||
                     ((st_q == S_LOGS) && log_done);
      div_start_q <= (st_q == S_DIVA) && (vcnt_q != '0);
      if (emit_go) out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
      case (st_q)
        S_IDLE: begin
          if (s_acc && (smp != '0)) begin
            d_q    <= (SAMPLE_W+1)'(smp) - (SAMPLE_W+1)'(prev_q);
            prev_q <= smp;
            st_q   <= S_SQ;
          end
        end
        S_SQ: begin
          sq_q <= sqw[31:0];
          st_q <= S_ACC;
        end
        S_ACC: begin
          sum_q <= sum_nx;
          cnt_q <= cnt_nx;
          if (cnt_nx >= len_eff) begin
            if (sum_nx == '0) begin
              cb_q <= SILENCE_CB;
              st_q <= S_WR;
            end else begin
              log_val_q <= sum_nx;
              st_q      <= S_LOGS;
            end
          end else begin
            st_q <= S_IDLE;
          end
        end
        S_LOGS: begin
          if (log_done) begin
            lsum_q    <= log_res;
            log_val_q <= SUMW'(cnt_q);
            st_q      <= S_LOGN;
          end
        end
        S_LOGN: begin
          if (log_done) begin
            diff_q <= $signed({1'b0, lsum_q}) - $signed({1'b0, log_res});
            st_q   <= S_MULX;
          end
        end
        S_MULX: begin
          x_q  <= XW'(diff_q) * XW'(LOG_K);
          st_q <= S_OFS;
        end
        S_OFS: begin
          // bias keeps the numerator positive and below 2^22
          ofs_q <= RCP_MW'(ZW'(x_q >>> 16) + ZW'(DB_OFS_BIASED));
          st_q  <= S_RCP;
        end
        S_RCP: begin
          rq_q <= rcp_prod[RPW-1:CB_SHIFT];
          st_q <= S_SAT;
        end
        S_SAT: begin
          if (cb_raw < (RQ_W+1)'(CB_MIN)) cb_q <= CB_MIN;
          else if (cb_raw > (RQ_W+1)'(CB_MAX)) cb_q <= CB_MAX;
          else cb_q <= LOUD_W'(cb_raw);
          st_q <= S_WR;
        end
        S_WR: begin
          sum_q <= '0;
          cnt_q <= '0;
          if (pos_q == RW'(BLOCKS_AVERAGED - 1)) begin
            pos_q    <= '0;
            rd_idx_q <= '0;
            acc_q    <= '0;
            vcnt_q   <= '0;
            st_q     <= S_RD;
          end else begin
            pos_q <= pos_q + 1'b1;
            st_q  <= S_IDLE;
          end
        end
        S_RD: begin
          st_q <= S_ACCV;
        end
        S_ACCV: begin
          // gate out silent blocks
          if (rdata_q > SILENCE_CB) begin
            acc_q  <= acc_q + AW'(rdata_q);
            vcnt_q <= vcnt_q + 1'b1;
          end
          if (rd_idx_q == RW'(BLOCKS_AVERAGED - 1)) begin
            st_q <= S_DIVA;
          end else begin
            rd_idx_q <= rd_idx_q + 1'b1;
            st_q     <= S_RD;
          end
        end
        S_DIVA: begin
          if (vcnt_q == '0) begin
            avg_q <= SILENCE_CB;
            st_q  <= S_EMIT;
          end else begin
            div_num_q <= ZW'(acc_q) + ZW'(acc_q) + ZW'(vcnt_q);
            div_den_q <= {vcnt_q, 1'b0};
            st_q      <= S_WAITA;
          end
        end
        S_WAITA: begin
          if (div_done) begin
            avg_q <= LOUD_W'(div_quot);
            st_q  <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_cb_q  <= avg_q;
            out_lvl_q <= level_code(avg_q);
            out_vb_q  <= vcnt_q;
            st_q      <= S_IDLE;
          end
        end
        default: st_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_TDATA_W - LOUD_W - LEVEL_W - VALID_W)'(0),
                          out_vb_q, out_lvl_q, out_cb_q};

`ifndef ASSERT_OFF
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, pos_q} < (RW+1)'(BLOCKS_AVERAGED))
    else $error("ring position out of range");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(MAX_BLOCK_LENGTH))
    else $error("sample count beyond max block length");

  a_emit_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == S_EMIT && out_valid_q && !m_axis_tready) |=> (st_q == S_EMIT))
    else $error("result dropped while output word pending");

  a_vb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_vb_q <= VALID_W'(BLOCKS_AVERAGED)))
    else $error("valid block count too large");
`endif

endmodule

// ----- rtl/core/blm_log2.sv -----
// iterative log2 unit: leading-one shift search then repeated squaring, q16 result
module blm_log2 import blm_pkg::*; #(
  parameter int unsigned VW = 44,
  localparam int unsigned PW = $clog2(VW),
  localparam int unsigned LW = PW + FRAC_W
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [VW-1:0] value_i,
  output logic          done_o,
  output logic [LW-1:0] result_o
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_MUL, L_CMP} lstate_e;

  lstate_e                   st_q;
  logic [VW-1:0]             v_q;
  logic [PW-1:0]             p_q;
  logic [MANT_W-1:0]         mant_q;
  logic [2*MANT_W-1:0]       prod_q;
  logic [FRAC_W-1:0]         frac_q;
  logic [$clog2(FRAC_W)-1:0] it_q;
  logic                      done_q;

  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     t;

  assign sq = (2*MANT_W)'(mant_q) * (2*MANT_W)'(mant_q);
  assign t  = prod_q[MANT_W-1 +: MANT_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= L_IDLE;
      v_q    <= '0;
      p_q    <= '0;
      mant_q <= '0;
      prod_q <= '0;
      frac_q <= '0;
      it_q   <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= (st_q == L_CMP) && (it_q == '0);
      case (st_q)
        L_IDLE: begin
          if (start_i) begin
            v_q  <= value_i;
            p_q  <= PW'(VW-1);
            st_q <= L_NORM;
          end
        end
        L_NORM: begin
          // one bit of the leading-one search per cycle
          if (v_q[VW-1]) begin
            mant_q <= v_q[VW-1 -: MANT_W];
            frac_q <= '0;
            it_q   <= '1;
            st_q   <= L_MUL;
          end else begin
            v_q <= v_q << 1;
            p_q <= p_q - 1'b1;
          end
        end
        L_MUL: begin
          prod_q <= sq;
          st_q   <= L_CMP;
        end
        L_CMP: begin
          if (t[MANT_W]) begin
            mant_q       <= t[MANT_W:1];
            frac_q[it_q] <= 1'b1;
          end else begin
            mant_q <= t[MANT_W-1:0];
          end
          if (it_q == '0) begin
            st_q <= L_IDLE;
          end else begin
            it_q <= it_q - 1'b1;
            st_q <= L_MUL;
          end
        end
        default: st_q <= L_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = {p_q, frac_q};

endmodule

// ----- rtl/core/blm_div.sv -----
// bit-serial signed floor divider by an unsigned denominator
module blm_div import blm_pkg::*; #(
  parameter int unsigned NW = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic signed [NW-1:0] num_i,
  input  logic [DIV_DW-1:0]    den_i,
  output logic                 done_o,
  output logic signed [NW-1:0] quot_o
);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_e;

  dstate_e                st_q;
  logic [NW-1:0]          a_q;
  logic [NW-1:0]          q_q;
  logic [DIV_DW:0]        r_q;
  logic [DIV_DW-1:0]      den_q;
  logic                   neg_q;
  logic [$clog2(NW)-1:0]  cnt_q;
  logic                   done_q;
  logic signed [NW-1:0]   quot_q;

  logic [DIV_DW:0] r_sh;
  logic            fits;

  assign r_sh = {r_q[DIV_DW-1:0], a_q[NW-1]};
  assign fits = r_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= D_IDLE;
      a_q    <= '0;
      q_q    <= '0;
      r_q    <= '0;
      den_q  <= '0;
      neg_q  <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
      quot_q <= '0;
    end else begin
      done_q <= (st_q == D_FIX);
      case (st_q)
        D_IDLE: begin
          if (start_i) begin
            neg_q <= num_i[NW-1];
            a_q   <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
            r_q   <= '0;
            q_q   <= '0;
            den_q <= den_i;
            cnt_q <= $clog2(NW)'(NW-1);
            st_q  <= D_RUN;
          end
        end
        D_RUN: begin
          r_q <= fits ? (r_sh - {1'b0, den_q}) : r_sh;
          q_q <= {q_q[NW-2:0], fits};
          a_q <= a_q << 1;
          if (cnt_q == '0) st_q <= D_FIX;
          else cnt_q <= cnt_q - 1'b1;
        end
        D_FIX: begin
          // negative numerator rounds toward minus infinity
          if (neg_q) quot_q <= -$signed(q_q) - ((r_q != '0) ? NW'(1) : NW'(0));
          else quot_q <= $signed(q_q);
          st_q <= D_IDLE;
        end
        default: st_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
